// ===== rtl/u2u8_pkg.sv =====
// Shared types, constants and UTF-8 encode helpers for the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

	localparam int unsigned UNIT_W         = 16;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned CP_W           = 21;
	localparam int unsigned INDEX_W        = 17;
	localparam int unsigned CMD_FIFO_DEPTH = 2;

	localparam logic [UNIT_W-1:0]  MAX_CHARS_RST = 16'd256;
	localparam logic [UNIT_W-1:0]  HIGH_FIRST    = 16'hD800;
	localparam logic [UNIT_W-1:0]  HIGH_LAST     = 16'hDBFF;
	localparam logic [UNIT_W-1:0]  LOW_FIRST     = 16'hDC00;
	localparam logic [UNIT_W-1:0]  LOW_LAST      = 16'hDFFF;
	localparam logic [INDEX_W-1:0] INDEX_MAX     = '1;
	localparam logic [CP_W-1:0]    ELLIPSIS_CP   = 21'h002026;
	localparam logic [CP_W-1:0]    CP_2BYTE      = 21'h000080;
	localparam logic [CP_W-1:0]    CP_3BYTE      = 21'h000800;
	localparam logic [CP_W-1:0]    CP_4BYTE      = 21'h010000;
	localparam logic [UNIT_W-1:0]  CH_TAB        = 16'h0009;
	localparam logic [UNIT_W-1:0]  CH_LF         = 16'h000A;
	localparam logic [UNIT_W-1:0]  CH_CR         = 16'h000D;
	localparam logic [UNIT_W-1:0]  CH_SPACE      = 16'h0020;

	typedef enum logic [1:0] {
		LEN1 = 2'd0,
		LEN2 = 2'd1,
		LEN3 = 2'd2,
		LEN4 = 2'd3
	} seq_len_t;

	// One classified unit: up to two code points to encode, in order.
	typedef struct packed {
		logic             last;
		logic             two;
		logic [CP_W-1:0]  cp0;
		seq_len_t         len0;
		logic [CP_W-1:0]  cp1;
		seq_len_t         len1;
	} cmd_t;

	function automatic seq_len_t seq_len(input logic [CP_W-1:0] cp);
		seq_len_t l;
		if (cp < CP_2BYTE) begin
			l = LEN1;
		end else if (cp < CP_3BYTE) begin
			l = LEN2;
		end else if (cp < CP_4BYTE) begin
			l = LEN3;
		end else begin
			l = LEN4;
		end
		return l;
	endfunction

	function automatic logic [BYTE_W-1:0] utf8_byte(input logic [CP_W-1:0] cp,
	                                                input seq_len_t len,
	                                                input logic [1:0] pos);
		logic [BYTE_W-1:0] b;
		b = '0;
		unique case (len)
			LEN1: b = cp[7:0];
			LEN2: begin
				unique case (pos)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LEN3: begin
				unique case (pos)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				unique case (pos)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/u2u8_if.sv =====
// Channel interfaces: code unit input, byte output and max_chars write port.
interface u2u8_unit_if;
	import u2u8_pkg::*;
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              is_last;
	modport source (output valid, code_unit, is_last, input ready);
	modport sink   (input valid, code_unit, is_last, output ready);
endinterface

interface u2u8_byte_if;
	import u2u8_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              string_end;
	modport source (output valid, out_byte, run_last, string_end, input ready);
	modport sink   (input valid, out_byte, run_last, string_end, output ready);
endinterface

interface u2u8_cfg_if;
	import u2u8_pkg::*;
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/u2u8_front.sv =====
// Front end: accepts code units, tracks surrogate and index state, emits encode commands.
module u2u8_front (
	input  logic               clk,
	input  logic               arst_n,
	u2u8_unit_if.sink          unit_ch,
	u2u8_cfg_if.sink           cfg_ch,
	input  logic               cmd_full,
	output logic               cmd_push,
	output u2u8_pkg::cmd_t     cmd
);
	import u2u8_pkg::*;

	logic [UNIT_W-1:0]  max_chars_q;
	logic [UNIT_W-1:0]  held_high_q;
	logic               held_valid_q;
	logic [INDEX_W-1:0] unit_index_q;

	logic [UNIT_W-1:0]  c;
	logic [UNIT_W-1:0]  c_mapped;
	logic [INDEX_W:0]   index_p1;
	logic               kept;
	logic               next_kept;
	logic               is_high;
	logic               is_low;
	logic               pair;
	logic               hold_now;
	logic               enc_c;
	logic               ellip;
	logic               xv;
	logic [CP_W-1:0]    x_cp;
	logic [CP_W-1:0]    held_cp;
	logic               accept;

	assign c         = unit_ch.code_unit;
	assign index_p1  = {1'b0, unit_index_q} + {{INDEX_W{1'b0}}, 1'b1};
	assign kept      = unit_index_q < {1'b0, max_chars_q};
	assign next_kept = index_p1 < {2'b00, max_chars_q};
	assign is_high   = (c >= HIGH_FIRST) && (c <= HIGH_LAST);
	assign is_low    = (c >= LOW_FIRST) && (c <= LOW_LAST);
	assign pair      = held_valid_q && is_low && kept;
	assign hold_now  = kept && !pair && is_high && !unit_ch.is_last && next_kept;
	assign enc_c     = kept && !pair && !hold_now;
	assign ellip     = unit_ch.is_last && !kept;
	assign xv        = enc_c || ellip;
	assign c_mapped  = (c == CH_LF || c == CH_CR || c == CH_TAB) ? CH_SPACE : c;
	assign x_cp      = ellip ? ELLIPSIS_CP : {{(CP_W-UNIT_W){1'b0}}, c_mapped};
	assign held_cp   = pair ? (CP_4BYTE + {1'b0, held_high_q[9:0], c[9:0]})
	                        : {{(CP_W-UNIT_W){1'b0}}, held_high_q};

	always_comb begin
		cmd      = '0;
		cmd.last = unit_ch.is_last;
		if (held_valid_q) begin
			cmd.cp0  = held_cp;
			cmd.len0 = seq_len(held_cp);
			cmd.two  = xv;
			cmd.cp1  = x_cp;
			cmd.len1 = seq_len(x_cp);
		end else begin
			cmd.cp0  = x_cp;
			cmd.len0 = seq_len(x_cp);
			cmd.two  = 1'b0;
			cmd.cp1  = x_cp;
			cmd.len1 = seq_len(x_cp);
		end
	end

	assign unit_ch.ready = !cmd_full;
	assign cfg_ch.ready  = 1'b1;
	assign accept        = unit_ch.valid && unit_ch.ready;
	assign cmd_push      = accept && (held_valid_q || xv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q  <= MAX_CHARS_RST;
			held_valid_q <= 1'b0;
			unit_index_q <= '0;
		end else begin
			if (cfg_ch.valid) begin
				max_chars_q <= cfg_ch.data;
			end
			if (accept) begin
				if (unit_ch.is_last) begin
					held_valid_q <= 1'b0;
					unit_index_q <= '0;
				end else begin
					held_valid_q <= hold_now;
					if (unit_index_q != INDEX_MAX) begin
						unit_index_q <= index_p1[INDEX_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_now) begin
			held_high_q <= c;
		end
	end

endmodule

// ===== rtl/u2u8_fifo.sv =====
// Small register FIFO between the front end and the byte serializer.
module u2u8_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_FULL;
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/u2u8_back.sv =====
// Back end: walks each command byte by byte into the output register.
module u2u8_back (
	input  logic               clk,
	input  logic               arst_n,
	input  u2u8_pkg::cmd_t     cmd,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	u2u8_byte_if.source        byte_ch
);
	import u2u8_pkg::*;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              run_last_q;
	logic              string_end_q;
	logic              sym_q;
	logic [1:0]        pos_q;

	logic              advance;
	logic              take;
	logic [CP_W-1:0]   cur_cp;
	seq_len_t          cur_len;
	logic              sym_end;
	logic              cmd_end;

	assign advance = !out_valid_q || byte_ch.ready;
	assign take    = advance && !cmd_empty;
	assign cur_cp  = sym_q ? cmd.cp1 : cmd.cp0;
	assign cur_len = sym_q ? cmd.len1 : cmd.len0;
	assign sym_end = pos_q == 2'(cur_len);
	assign cmd_end = sym_end && (sym_q || !cmd.two);
	assign cmd_pop = take && cmd_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sym_q       <= 1'b0;
			pos_q       <= '0;
		end else if (advance) begin
			out_valid_q <= !cmd_empty;
			if (take) begin
				if (cmd_end) begin
					sym_q <= 1'b0;
					pos_q <= '0;
				end else if (sym_end) begin
					sym_q <= 1'b1;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q   <= utf8_byte(cur_cp, cur_len, pos_q);
			run_last_q   <= cmd_end;
			string_end_q <= cmd_end && cmd.last;
		end
	end

	assign byte_ch.valid      = out_valid_q;
	assign byte_ch.out_byte   = out_byte_q;
	assign byte_ch.run_last   = run_last_q;
	assign byte_ch.string_end = string_end_q;

endmodule

// ===== rtl/utf16_to_utf8_truncating_transcoder.sv =====
// UTF-16 to UTF-8 transcoder with truncation: top level.
// One UTF-16 code unit is taken per cycle while the command queue between the
// classifier and the byte serializer has room; the serializer emits one UTF-8
// byte per cycle while the sink is ready. A plain unit yields 1 to 3 bytes, a
// surrogate pair 4 (none while a high surrogate is held), up to 6 when a held
// surrogate is flushed alongside a unit or when the ellipsis E2 80 A6 closes a
// truncated string. The output byte register sets the sustained rate; the
// queue (FIFO_DEPTH commands) absorbs short stalls. The user writes max_chars
// (reset 256) through cfg_ch only while the block is idle; this is unchecked.
module utf16_to_utf8_truncating_transcoder #(
	parameter int unsigned FIFO_DEPTH = u2u8_pkg::CMD_FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	u2u8_unit_if.sink    unit_ch,
	u2u8_cfg_if.sink     cfg_ch,
	u2u8_byte_if.source  byte_ch
);
	import u2u8_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic cmd_push;
	logic cmd_pop;
	logic cmd_full;
	logic cmd_empty;

	u2u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.unit_ch  (unit_ch),
		.cfg_ch   (cfg_ch),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (push_cmd)
	);

	u2u8_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (push_cmd),
		.pop     (cmd_pop),
		.rd_data (head_cmd),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	u2u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.byte_ch   (byte_ch)
	);

endmodule

// ===== tb/utf8_stream_checker.sv =====
// Checker: watches the unit, config and byte channels, predicts UTF-8 bytes and compares.
`timescale 1ns / 100ps
module utf8_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	u2u8_unit_if        unit_ch,
	u2u8_cfg_if         cfg_ch,
	u2u8_byte_if        byte_ch,
	output int          mismatches,
	output int          bytes_pending
);
	import u2u8_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              string_end;
	} utf8_out_t;

	logic [UNIT_W-1:0]  limit_chars;
	logic [UNIT_W-1:0]  held_unit;
	logic               held_ok;
	logic [INDEX_W-1:0] unit_idx;
	utf8_out_t          utf8_expected[$];
	logic [BYTE_W-1:0]  step_bytes[$];
	int                 fails;

	function automatic void add_byte(input logic [BYTE_W-1:0] b);
		step_bytes.insert(step_bytes.size(), b);
	endfunction

	function automatic void append_utf8(input logic [CP_W-1:0] cp);
		logic [BYTE_W-1:0] b;
		if (cp < CP_2BYTE) begin
			b = cp[7:0];
			if (b == CH_TAB[7:0] || b == CH_LF[7:0] || b == CH_CR[7:0]) b = CH_SPACE[7:0];
			add_byte(b);
		end else if (cp < CP_3BYTE) begin
			add_byte(8'hC0 | 8'(cp >> 6));
			add_byte(8'h80 | 8'(cp & 21'h3F));
		end else if (cp < CP_4BYTE) begin
			add_byte(8'hE0 | 8'(cp >> 12));
			add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
			add_byte(8'h80 | 8'(cp & 21'h3F));
		end else begin
			add_byte(8'hF0 | 8'(cp >> 18));
			add_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
			add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
			add_byte(8'h80 | 8'(cp & 21'h3F));
		end
	endfunction

	task automatic predict_utf8(input logic [UNIT_W-1:0] cu, input logic last);
		logic      kept;
		logic      is_high;
		logic      is_low;
		logic      paired;
		int        n;
		utf8_out_t item;
		step_bytes.delete();
		kept    = unit_idx < {1'b0, limit_chars};
		is_high = cu >= HIGH_FIRST && cu <= HIGH_LAST;
		is_low  = cu >= LOW_FIRST && cu <= LOW_LAST;
		paired  = 1'b0;
		if (held_ok) begin
			if (is_low && kept) begin
				append_utf8(CP_4BYTE + {1'b0, held_unit[9:0], cu[9:0]});
				paired = 1'b1;
			end else begin
				append_utf8({5'd0, held_unit});
			end
			held_ok   = 1'b0;
			held_unit = '0;
		end
		if (!paired && kept) begin
			if (is_high && !last && (int'(unit_idx) + 1 < int'(limit_chars))) begin
				held_unit = cu;
				held_ok   = 1'b1;
			end else begin
				append_utf8({5'd0, cu});
			end
		end
		if (last) begin
			if (!kept) append_utf8(ELLIPSIS_CP);
			held_ok   = 1'b0;
			held_unit = '0;
			unit_idx  = '0;
		end else if (unit_idx != INDEX_MAX) begin
			unit_idx++;
		end
		n = step_bytes.size();
		for (int k = 0; k < n; k++) begin
			item.out_byte   = step_bytes[k];
			item.run_last   = (k == n - 1);
			item.string_end = (k == n - 1) && last;
			utf8_expected.insert(utf8_expected.size(), item);
		end
	endtask

	task automatic check_byte();
		utf8_out_t want;
		if (utf8_expected.size() == 0) begin
			$error("unexpected byte transfer: out_byte %h", byte_ch.out_byte);
			fails++;
		end else begin
			want = utf8_expected.pop_front();
			if (byte_ch.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, got %h", want.out_byte, byte_ch.out_byte);
				fails++;
			end
			if (byte_ch.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, byte_ch.run_last);
				fails++;
			end
			if (byte_ch.string_end !== want.string_end) begin
				$error("string_end: expected %b, got %b", want.string_end, byte_ch.string_end);
				fails++;
			end
		end
	endtask

	initial begin
		fails = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_chars = MAX_CHARS_RST;
			held_unit   = '0;
			held_ok     = 1'b0;
			unit_idx    = '0;
			utf8_expected.delete();
			bytes_pending <= 0;
			mismatches    <= fails;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) limit_chars = cfg_ch.data;
			// predict first: a byte leaving now never stems from the unit entering now
			if (unit_ch.valid && unit_ch.ready) predict_utf8(unit_ch.code_unit, unit_ch.is_last);
			if (byte_ch.valid && byte_ch.ready) check_byte();
			bytes_pending <= utf8_expected.size();
			mismatches    <= fails;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, unit and config stimulus, byte sink, watchdog and verdict.
`timescale 1ns / 100ps
module testbench;
	import u2u8_pkg::*;

	localparam int RAND_ITEMS   = 410;
	localparam int STALL_LIMIT  = 5000;
	localparam int LONG_HOLD    = 200;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;
	logic idle_on;
	int   hold_asked = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;
	int   mismatches;
	int   bytes_pending;
	int   str_left = 0;

	u2u8_unit_if unit_ch ();
	u2u8_cfg_if  cfg_ch ();
	u2u8_byte_if byte_ch ();

	utf16_to_utf8_truncating_transcoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.unit_ch (unit_ch),
		.cfg_ch  (cfg_ch),
		.byte_ch (byte_ch)
	);

	utf8_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.unit_ch       (unit_ch),
		.cfg_ch        (cfg_ch),
		.byte_ch       (byte_ch),
		.mismatches    (mismatches),
		.bytes_pending (bytes_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// byte sink: random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			byte_ch.ready <= 1'b0;
		end else if (hold_asked != hold_served) begin
			hold_served = hold_served + 1;
			hold_left = LONG_HOLD - 1;
			byte_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			byte_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 5);
			byte_ch.ready <= 1'b0;
		end else begin
			byte_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (unit_ch.valid && unit_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic send_unit(input logic [UNIT_W-1:0] cu, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			unit_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		unit_ch.valid     <= 1'b1;
		unit_ch.code_unit <= cu;
		unit_ch.is_last   <= last;
		@(posedge clk);
		while (!unit_ch.ready) @(posedge clk);
	endtask

	task automatic drain_and_rest();
		unit_ch.valid <= 1'b0;
		do @(posedge clk); while (bytes_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_chars(input logic [UNIT_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [UNIT_W-1:0] pick_unit();
		logic [UNIT_W-1:0] u;
		case ($urandom_range(0, 9))
			0:       u = UNIT_W'($urandom_range(0, 31));
			1, 2:    u = UNIT_W'($urandom_range(32, 127));
			3:       u = UNIT_W'($urandom_range(16'h0080, 16'h07FF));
			4:       u = UNIT_W'($urandom_range(16'h0800, 16'hD7FF));
			5:       u = UNIT_W'($urandom_range(16'hE000, 16'hFFFF));
			6:       u = UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST));
			7:       u = UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST));
			default: u = UNIT_W'($urandom());
		endcase
		return u;
	endfunction

	function automatic logic [UNIT_W-1:0] pick_limit(input int phase);
		logic [UNIT_W-1:0] v;
		if (phase == 0) begin
			v = 16'd1;
		end else if (phase == 1) begin
			v = 16'hFFFF;
		end else begin
			case ($urandom_range(0, 7))
				0:       v = 16'hFFFF;
				1:       v = MAX_CHARS_RST;
				2:       v = UNIT_W'($urandom_range(1, 16'hFFFF));
				3:       v = 16'd1;
				4:       v = UNIT_W'($urandom_range(9, 40));
				default: v = UNIT_W'($urandom_range(2, 8));
			endcase
		end
		return v;
	endfunction

	// strings carry over between calls so that limit changes land mid-string
	task automatic send_strings(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if (str_left == 0)
				str_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			if (str_left >= 2 && $urandom_range(0, 3) == 0) begin
				send_unit(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0);
				send_unit(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)), str_left == 2);
				str_left -= 2;
				sent += 2;
			end else begin
				send_unit(pick_unit(), str_left == 1);
				str_left--;
				sent++;
			end
		end
	endtask

	initial begin
		int rand_sent;
		int phase;
		int chunk;
		arst_n            <= 1'b0;
		idle_on           <= 1'b1;
		unit_ch.valid     <= 1'b0;
		unit_ch.code_unit <= '0;
		unit_ch.is_last   <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.data       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: size classes, control chars, pairs, lone surrogates
		send_unit(16'h0000, 1'b0);
		send_unit(CH_TAB, 1'b0);
		send_unit(CH_LF, 1'b0);
		send_unit(CH_CR, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(HIGH_FIRST, 1'b0);
		send_unit(LOW_FIRST, 1'b0);
		send_unit(HIGH_LAST, 1'b0);
		send_unit(LOW_LAST, 1'b0);
		send_unit(LOW_LAST, 1'b0);
		send_unit(16'hD83D, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(HIGH_FIRST, 1'b1);
		// high at last kept position, then truncation with ellipsis
		drain_and_rest();
		write_max_chars(16'd2);
		send_unit(16'h0041, 1'b0);
		send_unit(HIGH_FIRST, 1'b0);
		send_unit(16'h0042, 1'b0);
		send_unit(16'h0043, 1'b1);
		// held high, then limit lowered mid-string
		drain_and_rest();
		write_max_chars(16'd3);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hD801, 1'b0);
		drain_and_rest();
		write_max_chars(16'd1);
		send_unit(16'hDC01, 1'b1);
		// zero limit: ellipsis only
		drain_and_rest();
		write_max_chars(16'd0);
		send_unit(16'h0041, 1'b1);

		rand_sent = 0;
		phase = 0;
		while (rand_sent < RAND_ITEMS) begin
			chunk = $urandom_range(30, 50);
			drain_and_rest();
			write_max_chars(pick_limit(phase));
			idle_on <= (RAND_ITEMS - rand_sent > 70) && ($urandom_range(0, 3) != 0);
			if (phase == 1) hold_asked++;
			if (phase == 2) begin
				send_strings(chunk / 2);
				drain_and_rest();
				send_strings(chunk - chunk / 2);
			end else begin
				send_strings(chunk);
			end
			rand_sent += chunk;
			phase++;
		end

		drain_and_rest();
		if (mismatches == 0 && bytes_pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
